// ----- sv/prime_test_and_rank_defines.svh -----
// ----------------------------------------------------------------------------
// prime_test_and_rank_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PRIME_TEST_AND_RANK_DEFINES_SVH
`define PRIME_TEST_AND_RANK_DEFINES_SVH

// same-cycle implication
`define PTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ptr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptr_pkg: shared types and constants
// Field widths, table depth and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ptr_pkg;

  localparam int VALUE_W = 10;            // input value width
  localparam int RANK_W  = 8;             // rank field width
  localparam int ADDR_W  = VALUE_W;       // table address width
  localparam int DEPTH   = 1 << ADDR_W;   // table entries
  localparam int SQ_W    = ADDR_W + 1;    // sieve multiple / square width
  localparam int P_W     = 6;             // sieve base, at most 32
  localparam int CMP_W   = 16;            // range compare width

  // commands from controller to datapath
  typedef struct packed {
    logic k_clr;
    logic clr_wr;
    logic sieve_rd;
    logic p_inc;
    logic mark_init;
    logic mark_wr;
    logic rank_rd;
    logic lookup_rd;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic k_last;
    logic psq_over;
    logic comp_bit;
    logic mark_last;
  } stat_t;

endpackage

// ----- sv/ptr_datapath.sv -----
// ----------------------------------------------------------------------------
// ptr_datapath: sieve memory, rank table and result registers
// Builds a composite-flag sieve, turns it into a rank table, then serves
// lookups of the table for each input word.
// ----------------------------------------------------------------------------
`include "prime_test_and_rank_defines.svh"

module ptr_datapath #(
  parameter int MAX_VALUE = 1023
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptr_pkg::cmd_t                 cmd,
  output ptr_pkg::stat_t                stat,
  input  logic [ptr_pkg::VALUE_W-1:0]   value,
  output logic                          is_prime,
  output logic [ptr_pkg::RANK_W-1:0]    prime_rank,
  output logic                          out_of_range
);

  localparam int AW   = ptr_pkg::ADDR_W;
  localparam int MW   = ptr_pkg::SQ_W;
  localparam int RW   = ptr_pkg::RANK_W;
  localparam int PW   = ptr_pkg::P_W;
  localparam int CW   = ptr_pkg::CMP_W;
  localparam int LAST_INT = (MAX_VALUE < ptr_pkg::DEPTH - 1) ? MAX_VALUE : ptr_pkg::DEPTH - 1;
  localparam logic [AW-1:0] LAST   = AW'(LAST_INT);
  localparam logic [MW-1:0] LAST_W = MW'(LAST_INT);
  localparam logic [CW-1:0] MAX_V  = CW'(MAX_VALUE);

  // memories
  logic          comp_mem [ptr_pkg::DEPTH];
  logic [RW-1:0] rank_mem [ptr_pkg::DEPTH];

  // build counters and pipeline
  logic [AW-1:0] k;
  logic [AW-1:0] k_d;
  logic [PW-1:0] p;
  logic [MW-1:0] psq;
  logic [MW-1:0] m;
  logic [RW-1:0] cnt;
  logic          comp_q;
  logic          rank_pend;

  // lookup registers
  logic [RW-1:0]                rank_q;
  logic [ptr_pkg::VALUE_W-1:0]  val_q;

  logic          is_new;
  logic [RW-1:0] cnt_inc;
  logic [RW-1:0] rank_wr_data;
  logic [MW-1:0] m_step;
  logic          val_oor;

  // rank pass: a clear flag at index two or above is a new prime
  assign is_new       = (k_d >= AW'(2)) && !comp_q;
  assign cnt_inc      = cnt + RW'(1);
  assign rank_wr_data = is_new ? cnt_inc : '0;
  assign m_step       = m + MW'(p);
  assign val_oor      = CW'(val_q) > MAX_V;

  // status back to the controller
  assign stat.k_last    = (k == LAST);
  assign stat.psq_over  = (psq > LAST_W);
  assign stat.comp_bit  = comp_q;
  assign stat.mark_last = (m_step > LAST_W);

  // sieve flag memory, write port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      comp_mem[k] <= 1'b0;
    end else if (cmd.mark_wr) begin
      comp_mem[m[AW-1:0]] <= 1'b1;
    end
  end

  // sieve flag memory, registered read port
  always_ff @(posedge clk) begin
    if (cmd.sieve_rd) begin
      comp_q <= comp_mem[AW'(p)];
    end else if (cmd.rank_rd) begin
      comp_q <= comp_mem[k];
    end
  end

  // rank table, write and registered read
  always_ff @(posedge clk) begin
    if (rank_pend) begin
      rank_mem[k_d] <= rank_wr_data;
    end
    if (cmd.lookup_rd) begin
      rank_q <= rank_mem[value];
    end
  end

  // build counters
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      p         <= PW'(2);
      cnt       <= '0;
      rank_pend <= 1'b0;
    end else begin
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.clr_wr || cmd.rank_rd) begin
        k <= k + AW'(1);
      end
      if (cmd.p_inc) begin
        p <= p + PW'(1);
      end
      if (rank_pend && is_new) begin
        cnt <= cnt_inc;
      end
      rank_pend <= cmd.rank_rd;
    end
  end

  // sieve square, multiple walk and rank pipeline address
  always_ff @(posedge clk) begin
    if (cmd.sieve_rd) begin
      psq <= MW'(p) * MW'(p);
    end
    if (cmd.mark_init) begin
      m <= psq;
    end else if (cmd.mark_wr) begin
      m <= m_step;
    end
    if (cmd.rank_rd) begin
      k_d <= k;
    end
    if (cmd.lookup_rd) begin
      val_q <= value;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_of_range <= val_oor;
      prime_rank   <= val_oor ? '0 : rank_q;
      is_prime     <= !val_oor && ((val_q == AW'(1)) || (rank_q != '0));
    end
  end

  `PTR_ASSERT_IMPL(a_mark_in_range, cmd.mark_wr, m <= LAST_W, "sieve mark beyond table end")
  `PTR_ASSERT_IMPL(a_lookup_after_build, cmd.lookup_rd, !rank_pend, "lookup during table write")

endmodule

// ----- sv/ptr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptr_ctrl: build and lookup sequencer
// Runs the clear, sieve and rank passes after reset, then handles the
// input and output handshakes one word at a time.
// ----------------------------------------------------------------------------
`include "prime_test_and_rank_defines.svh"

module ptr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ptr_pkg::cmd_t  cmd,
  input  ptr_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_SIEVE_RD,
    S_SIEVE_CHK,
    S_MARK,
    S_RANK,
    S_RANK_END,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.k_last) begin
          cmd.k_clr  = 1'b1;
          state_next = S_SIEVE_RD;
        end
      end
      S_SIEVE_RD: begin
        cmd.sieve_rd = 1'b1;
        state_next   = S_SIEVE_CHK;
      end
      S_SIEVE_CHK: begin
        if (stat.psq_over) begin
          state_next = S_RANK;
        end else if (stat.comp_bit) begin
          cmd.p_inc  = 1'b1;
          state_next = S_SIEVE_RD;
        end else begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark_wr = 1'b1;
        if (stat.mark_last) begin
          cmd.p_inc  = 1'b1;
          state_next = S_SIEVE_RD;
        end
      end
      S_RANK: begin
        cmd.rank_rd = 1'b1;
        if (stat.k_last) begin
          state_next = S_RANK_END;
        end
      end
      S_RANK_END: begin
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.lookup_rd = 1'b1;
          state_next    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PTR_ASSERT_IMPL(a_load_free, cmd.out_load, out_free, "result loaded over an untaken word")
  `PTR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken during lookup")

endmodule

// ----- sv/prime_test_and_rank.sv -----
// ----------------------------------------------------------------------------
// prime_test_and_rank: primality test with rank among the primes
// Top level joining the build/lookup sequencer and the table datapath.
// ----------------------------------------------------------------------------
// After reset the block builds a table of ranks: it clears a sieve of flags
// up to min(MAX_VALUE, 1023), strikes out multiples of each base whose square
// fits, then walks the flags once, counting primes and writing each entry's
// rank. in_ready stays low for this build. After that each word goes
// through the single table read port: accept and registered read, then
// load of the result register; a new word is not taken until the prior one
// has been loaded. A word is still taken while the prior result waits for
// out_ready, but its load then waits as well.
// The value 1 reports prime with rank 0; a value above MAX_VALUE sets
// out_of_range and zeroes the other fields.
// ----------------------------------------------------------------------------
module prime_test_and_rank #(
  parameter int MAX_VALUE = 1023
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ptr_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_prime,
  output logic [ptr_pkg::RANK_W-1:0]   prime_rank,
  output logic                         out_of_range
);

  ptr_pkg::cmd_t  cmd;
  ptr_pkg::stat_t stat;

  // sequencer
  ptr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // sieve, rank table and result registers
  ptr_datapath #(
    .MAX_VALUE (MAX_VALUE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .is_prime     (is_prime),
    .prime_rank   (prime_rank),
    .out_of_range (out_of_range)
  );

endmodule
